// ===== sv/ddsc_pkg.sv =====
// ddsc_pkg: shared constants, state/command/status types for the sample collector.
// No dependencies; imported by every module of the block.
package ddsc_pkg;

    localparam int SLOTS = 32;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int CNT_W = 5;

    // 5 * dot > 4 * 32767^2
    localparam logic signed [42:0] SIM_LIM = 43'sd4294705156;
    localparam logic signed [15:0] UNIT_Q = 16'sd32767;

    typedef enum logic [1:0] {
        STS_STORED,
        STS_FROZEN,
        STS_ZERO,
        STS_SIMILAR
    } status_t;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_LAST,
        MUL_MEM
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_DIV,
        ST_LDOT,
        ST_LCHK,
        ST_RD,
        ST_SDOT,
        ST_SCHK,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic [1:0]       axis;
        logic             acc_clr;
        logic             acc_en;
        logic             root_init;
        logic             root_en;
        logic             div_init;
        logic             div_en;
        logic             div_store;
        logic             set_last;
        logic             mem_rd;
        logic [IDX_W-1:0] addr;
        logic             commit;
        logic             out_load;
        status_t          status;
        logic [IDX_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic frozen;
        logic in_zero;
        logic similar;
        logic stale;
        logic out_busy;
    } sts_t;

endpackage

// ===== sv/ddsc_datapath.sv =====
// ddsc_datapath: config registers, shared multiplier/accumulator, bit-serial sqrt,
// radix-2 divider, sample table memory and result register. Uses ddsc_pkg.
module ddsc_datapath import ddsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [79:0] s_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    logic [23:0]        window_reg;
    logic               frozen_reg;
    logic signed [31:0] t_reg;
    logic signed [15:0] vec_reg  [3];
    logic signed [15:0] dir_reg  [3];
    logic signed [15:0] last_reg [3];
    logic signed [31:0] prod_reg;
    logic signed [39:0] acc_reg;
    logic [31:0]        n_reg, root_reg, bit_reg;
    logic [15:0]        rem_reg, lo_reg, q_reg;

    logic [79:0]        mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    logic signed [31:0] rd_time_reg;
    logic [47:0]        rd_dir_reg;

    logic               m_tvalid_reg;
    logic [1:0]         m_status_reg;
    logic [7:0]         m_slot_reg;

    logic signed [15:0] mul_a, mul_b, vec_ax;
    logic [31:0]        root_sum;
    logic [16:0]        vmag, div_t;
    logic [31:0]        num;
    logic signed [42:0] dot5;
    logic signed [33:0] limit;

    always_comb begin
        case (cmd.axis)
            2'd0:    vec_ax = vec_reg[0];
            2'd1:    vec_ax = vec_reg[1];
            default: vec_ax = vec_reg[2];
        endcase
        mul_a = vec_ax;
        mul_b = vec_ax;
        case (cmd.mul_sel)
            MUL_SQ: begin
                mul_a = vec_ax;
                mul_b = vec_ax;
            end
            MUL_LAST: begin
                case (cmd.axis)
                    2'd0:    begin mul_a = dir_reg[0]; mul_b = last_reg[0]; end
                    2'd1:    begin mul_a = dir_reg[1]; mul_b = last_reg[1]; end
                    default: begin mul_a = dir_reg[2]; mul_b = last_reg[2]; end
                endcase
            end
            MUL_MEM: begin
                case (cmd.axis)
                    2'd0:    begin mul_a = dir_reg[0]; mul_b = rd_dir_reg[15:0];  end
                    2'd1:    begin mul_a = dir_reg[1]; mul_b = rd_dir_reg[31:16]; end
                    default: begin mul_a = dir_reg[2]; mul_b = rd_dir_reg[47:32]; end
                endcase
            end
            default: begin
                mul_a = vec_ax;
                mul_b = vec_ax;
            end
        endcase
    end

    assign root_sum = root_reg + bit_reg;
    assign vmag     = vec_ax[15] ? (17'd0 - {vec_ax[15], vec_ax}) : {1'b0, vec_ax};
    assign num      = ({15'd0, vmag} << 15) - {15'd0, vmag};
    assign div_t    = {rem_reg, lo_reg[15]};
    assign dot5     = ({{3{acc_reg[39]}}, acc_reg} <<< 2) + {{3{acc_reg[39]}}, acc_reg};
    assign limit    = {{2{t_reg[31]}}, t_reg} - {10'd0, window_reg};

    always_comb begin
        sts.frozen   = frozen_reg;
        sts.in_zero  = (s_tdata[79:32] == 48'd0);
        sts.similar  = (dot5 > SIM_LIM);
        sts.stale    = ($signed({{2{rd_time_reg[31]}}, rd_time_reg}) < limit);
        sts.out_busy = m_tvalid_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            frozen_reg  <= 1'b0;
            last_reg[0] <= UNIT_Q;
            last_reg[1] <= '0;
            last_reg[2] <= '0;
            valid_reg   <= '0;
        end else begin
            if (cfg_we) begin
                if (!cfg_addr) window_reg <= cfg_wdata;
                else           frozen_reg <= cfg_wdata[0];
            end
            if (cmd.set_last) begin
                last_reg <= dir_reg;
            end
            if (cmd.commit) begin
                valid_reg[cmd.slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg      <= s_tdata[31:0];
            vec_reg[0] <= s_tdata[47:32];
            vec_reg[1] <= s_tdata[63:48];
            vec_reg[2] <= s_tdata[79:64];
        end
        if (cmd.mul_en) begin
            prod_reg <= 32'(mul_a) * 32'(mul_b);
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + {{8{prod_reg[31]}}, prod_reg};
        end
        if (cmd.root_init) begin
            n_reg    <= acc_reg[31:0];
            root_reg <= '0;
            bit_reg  <= 32'h4000_0000;
        end else if (cmd.root_en) begin
            if (n_reg >= root_sum) begin
                n_reg    <= n_reg - root_sum;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init) begin
            rem_reg <= num[31:16];
            lo_reg  <= num[15:0];
            q_reg   <= '0;
        end else if (cmd.div_en) begin
            if (div_t >= {1'b0, root_reg[15:0]}) begin
                rem_reg <= 16'(div_t - {1'b0, root_reg[15:0]});
                q_reg   <= {q_reg[14:0], 1'b1};
            end else begin
                rem_reg <= div_t[15:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
            lo_reg <= {lo_reg[14:0], 1'b0};
        end
        if (cmd.div_store) begin
            case (cmd.axis)
                2'd0:    dir_reg[0] <= vec_ax[15] ? (16'sd0 - q_reg) : q_reg;
                2'd1:    dir_reg[1] <= vec_ax[15] ? (16'sd0 - q_reg) : q_reg;
                default: dir_reg[2] <= vec_ax[15] ? (16'sd0 - q_reg) : q_reg;
            endcase
        end
    end

    // sample table: {dir z, dir y, dir x, time}; unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            mem[cmd.slot] <= {dir_reg[2], dir_reg[1], dir_reg[0], t_reg};
        end
        if (cmd.mem_rd) begin
            if (valid_reg[cmd.addr]) begin
                rd_time_reg <= mem[cmd.addr][31:0];
                rd_dir_reg  <= mem[cmd.addr][79:32];
            end else begin
                rd_time_reg <= '0;
                rd_dir_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= cmd.status;
            m_slot_reg   <= 8'(cmd.slot);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_slot_reg, m_status_reg};

endmodule

// ===== sv/ddsc_ctrl.sv =====
// ddsc_ctrl: sequencer for one sample: normalize, check against last direction,
// scan the table, write and report. Uses ddsc_pkg; drives ddsc_datapath.
module ddsc_ctrl import ddsc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       ax_reg, ax_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] next_slot_reg, next_slot_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    status_t          status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ax_reg        <= '0;
            idx_reg       <= '0;
            next_slot_reg <= '0;
            slot_reg      <= '0;
            status_reg    <= STS_STORED;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ax_reg        <= ax_next;
            idx_reg       <= idx_next;
            next_slot_reg <= next_slot_next;
            slot_reg      <= slot_next;
            status_reg    <= status_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + CNT_W'(1);
        ax_next        = ax_reg;
        idx_next       = idx_reg;
        next_slot_next = next_slot_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MUL_SQ;
        cmd.status     = status_reg;
        cmd.slot       = slot_reg;
        cmd.addr       = idx_reg;
        cmd.axis       = ax_reg;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid) begin
                    cmd.load    = 1'b1;
                    cmd.acc_clr = 1'b1;
                    slot_next   = '0;
                    if (sts.frozen) begin
                        status_next = STS_FROZEN;
                        state_next  = ST_OUT;
                    end else if (sts.in_zero) begin
                        status_next = STS_ZERO;
                        state_next  = ST_OUT;
                    end else begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ, ST_LDOT, ST_SDOT: begin
                cmd.mul_sel = (state_reg == ST_SQ)   ? MUL_SQ :
                              (state_reg == ST_LDOT) ? MUL_LAST : MUL_MEM;
                cmd.axis    = cnt_reg[1:0];
                cmd.mul_en  = (cnt_reg < CNT_W'(3));
                cmd.acc_en  = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(3)) begin
                    cnt_next   = '0;
                    ax_next    = '0;
                    state_next = (state_reg == ST_SQ)   ? ST_ROOT :
                                 (state_reg == ST_LDOT) ? ST_LCHK : ST_SCHK;
                end
            end
            ST_ROOT: begin
                cmd.root_init = (cnt_reg == '0);
                cmd.root_en   = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(16)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_init  = (cnt_reg == '0);
                cmd.div_en    = (cnt_reg != '0) && (cnt_reg <= CNT_W'(16));
                cmd.div_store = (cnt_reg == CNT_W'(17));
                if (cnt_reg == CNT_W'(17)) begin
                    cnt_next = '0;
                    if (ax_reg == 2'd2) begin
                        cmd.acc_clr = 1'b1;
                        state_next  = ST_LDOT;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end
            end
            ST_LCHK: begin
                if (sts.similar) begin
                    status_next = STS_SIMILAR;
                    state_next  = ST_OUT;
                end else begin
                    cmd.set_last = 1'b1;
                    idx_next     = '0;
                    state_next   = ST_RD;
                end
            end
            ST_RD: begin
                cmd.mem_rd  = 1'b1;
                cmd.acc_clr = 1'b1;
                cnt_next    = '0;
                state_next  = ST_SDOT;
            end
            ST_SCHK: begin
                if (sts.stale || sts.similar) begin
                    slot_next  = idx_reg;
                    state_next = ST_WRITE;
                end else if (idx_reg == LAST_IDX) begin
                    slot_next  = next_slot_reg;
                    state_next = ST_WRITE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_WRITE: begin
                cmd.commit     = 1'b1;
                next_slot_next = (slot_reg == LAST_IDX) ? '0 : slot_reg + IDX_W'(1);
                status_next    = STS_STORED;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/direction_diverse_sample_collector.sv =====
// Direction-diverse sample collector: one result beat per sample beat. A frozen or
// zero sample goes straight to the result. Otherwise the sample is normalized (sum
// of squares, bit-serial square root, one radix-2 divide per axis), checked against
// the last direction, and the table is scanned one slot at a time (memory read plus
// 3 multiplies on the shared multiplier) before the sample is written. A new sample is
// taken while the previous result still waits on m_tready.
module direction_diverse_sample_collector import ddsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // timestamp, sample_x, sample_y, sample_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], slot_written[9:2], zero pad
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [23:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    ddsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ddsc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sv/ddsc_checker.sv =====
// ddsc_checker: port-level assertions for the sample collector, bound to the top.
// Uses ddsc_pkg.
module ddsc_checker import ddsc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped while stalled");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STS_STORED) |-> m_tdata[9:2] == 8'd0)
        else $error("slot nonzero on a rejected sample");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:2] <= 8'(SLOTS - 1)) && (m_tdata[15:10] == 6'd0))
        else $error("slot out of range or pad bits set");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind direction_diverse_sample_collector ddsc_checker u_ddsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_direction_diverse_sample_collector.sv =====
// Testbench for direction_diverse_sample_collector: directed and random sample beats,
// with a built-in predictor of the slot table checked against every result beat.
// Depends on ddsc_pkg and the collector RTL only.
module tb_direction_diverse_sample_collector;
    import ddsc_pkg::*;

    localparam int NSLOT = 32;
    localparam longint UQ = 32767;
    localparam int SETTLE = 400;

    typedef struct {
        status_t    st;
        logic [7:0] slot;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [23:0] cfg_wdata = '0;

    direction_diverse_sample_collector u_dut (.*);

    // predictor state
    int          tbl_time [NSLOT];
    shortint     tbl_vec  [NSLOT][3];
    longint      last_dir [3];
    int          ptr;
    logic [23:0] window_q;
    logic        frozen_q;

    verdict_t    verdict_q[$];
    int          errors = 0;
    bit          calm = 0;
    int          rx_cnt = 0;
    int          tnow = 0;
    shortint     pool [16][3];

    initial forever #1 aclk = ~aclk;

    initial begin
        #4000000;
        $display("direction_diverse_sample_collector verification failed");
        $finish;
    end

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic bit unit_dir(input longint v[3], output longint d[3]);
        longint unsigned sq;
        longint len;
        sq = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        if (sq == 0) return 0;
        len = longint'(isqrt(sq));
        for (int k = 0; k < 3; k++) d[k] = (v[k] * UQ) / len;
        return 1;
    endfunction

    function automatic bit near_dir(input longint a[3], input longint b[3]);
        longint dot;
        dot = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
        return dot * 5 > 4 * UQ * UQ;
    endfunction

    task automatic predict(input int t, input shortint sx, sy, sz);
        verdict_t r;
        longint v[3], nv[3], c[3], nc[3];
        longint lim;
        int slot;
        r.slot = 8'd0;
        v[0] = sx; v[1] = sy; v[2] = sz;
        if (frozen_q) begin
            r.st = STS_FROZEN;
        end else if (!unit_dir(v, nv)) begin
            r.st = STS_ZERO;
        end else if (near_dir(nv, last_dir)) begin
            r.st = STS_SIMILAR;
        end else begin
            last_dir = nv;
            slot = ptr;
            lim = longint'(t) - longint'(window_q);
            for (int i = 0; i < NSLOT; i++) begin
                if (longint'(tbl_time[i]) < lim) begin
                    slot = i;
                    break;
                end
                for (int k = 0; k < 3; k++) c[k] = tbl_vec[i][k];
                if (unit_dir(c, nc) && near_dir(nv, nc)) begin
                    slot = i;
                    break;
                end
            end
            tbl_time[slot] = t;
            tbl_vec[slot][0] = sx; tbl_vec[slot][1] = sy; tbl_vec[slot][2] = sz;
            ptr = (slot + 1) % NSLOT;
            r.st = STS_STORED;
            r.slot = 8'(slot);
        end
        verdict_q.push_back(r);
    endtask

    // called right after a rising edge; leaves s_tvalid high after the accepting edge
    task automatic send_sample(input int t, input shortint sx, sy, sz);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sz, sy, sx, t};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        predict(t, sx, sy, sz);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        s_tvalid <= 1'b0;
        wait (verdict_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == 1'b0) window_q = val;
        else frozen_q = val[0];
    endtask

    // result checker and receiver stall bursts
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, m_tdata);
                errors++;
            end else begin
                verdict_t e;
                e = verdict_q.pop_front();
                if (m_tdata[1:0] !== e.st) begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[9:2] !== e.slot) begin
                    $display("%0t: slot exp %0d got %0d", $time, e.slot, m_tdata[9:2]);
                    errors++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (rx_cnt > 0) begin
            rx_cnt <= rx_cnt - 1;
        end else begin
            m_tready <= ~m_tready;
            rx_cnt <= $urandom_range(0, 14);
        end
    end

    task automatic test_directed();
        write_reg(1'b0, 24'd0);
        write_reg(1'b1, 1'b0);
        send_sample(0, 16'sd32767, 0, 0);          // matches reset direction
        send_sample(0, 0, 0, 0);                   // zero vector
        send_sample(0, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(1, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-32'sd2147483648, 0, 16'sd32767, 0);
        send_sample(32'sd2147483647, 0, 0, -16'sd32768);
        send_sample(5, 16'sd1, -16'sd1, 0);
        send_sample(5, -16'sd1, -16'sd1, 16'sd1);
        write_reg(1'b0, 24'hFFFFFF);
        send_sample(-32'sd2147483648, 16'sd100, 16'sd3000, 0);
        send_sample(32'sd2147483647, -16'sd3000, 0, 16'sd5);
        send_sample(32'sd2147483647, 16'sd200, 16'sd6000, 0);  // like a stored slot
        send_sample(0, 0, 0, 16'sd1);
        write_reg(1'b1, 1'b1);
        send_sample(7, 16'sd123, 16'sd456, 16'sd789);
        send_sample(7, 0, 0, 0);
        write_reg(1'b1, 1'b0);
        write_reg(1'b0, 24'd10);
        send_sample(100, 16'sd5, 16'sd5, 16'sd5);
        send_sample(100, -16'sd5, 16'sd5, -16'sd5);
    endtask

    task automatic test_random(input int n);
        shortint sx, sy, sz;
        int p, s;
        for (int i = 0; i < n; i++) begin
            if (i == n - 80) calm = 1;
            if (i % 150 == 75) begin
                case ($urandom_range(0, 3))
                    0: write_reg(1'b0, 24'd0);
                    1: write_reg(1'b0, 24'hFFFFFF);
                    default: write_reg(1'b0, 24'($urandom_range(50, 20000)));
                endcase
                write_reg(1'b1, 1'($urandom_range(0, 5) == 0));
            end
            if ($urandom_range(0, 19) == 0) tnow = $urandom;
            else tnow = tnow + $urandom_range(0, 800);
            case ($urandom_range(0, 9))
                0, 1: begin
                    sx = $urandom; sy = $urandom; sz = $urandom;
                end
                2: begin
                    sx = 0; sy = 0; sz = 0;
                end
                default: begin
                    p = $urandom_range(0, 15);
                    s = $urandom_range(1, 4);
                    sx = pool[p][0] * s + shortint'($urandom_range(0, 40)) - 20;
                    sy = pool[p][1] * s + shortint'($urandom_range(0, 40)) - 20;
                    sz = pool[p][2] * s + shortint'($urandom_range(0, 40)) - 20;
                end
            endcase
            send_sample(tnow, sx, sy, sz);
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_time[i] = 0;
            tbl_vec[i] = '{0, 0, 0};
        end
        last_dir = '{UQ, 0, 0};
        ptr = 0;
        window_q = '0;
        frozen_q = 1'b0;
        for (int i = 0; i < 16; i++)
            for (int k = 0; k < 3; k++) pool[i][k] = shortint'($urandom_range(0, 16000)) - 8000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(730);
        s_tvalid <= 1'b0;
        wait (verdict_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("direction_diverse_sample_collector verification clean");
        end else begin
            $display("direction_diverse_sample_collector verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ddsc_pkg.sv
sv/ddsc_datapath.sv
sv/ddsc_ctrl.sv
sv/direction_diverse_sample_collector.sv
sv/ddsc_checker.sv
tb/tb_direction_diverse_sample_collector.sv
